// ===== hdl/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared constants for the touch event stroke decoder: event types and codes,
// configuration register indexes and reset maxima, rotation codes, stroke kinds and field widths.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int RAW_W      = 16;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ROT_W      = 2;

  localparam logic [15:0] EVT_SYN = 16'h0000;
  localparam logic [15:0] EVT_KEY = 16'h0001;
  localparam logic [15:0] EVT_ABS = 16'h0003;

  localparam logic [15:0] CODE_X         = 16'h0000;
  localparam logic [15:0] CODE_Y         = 16'h0001;
  localparam logic [15:0] CODE_MT_X      = 16'h0035;
  localparam logic [15:0] CODE_MT_Y      = 16'h0036;
  localparam logic [15:0] CODE_TRACK     = 16'h0039;
  localparam logic [15:0] CODE_BTN_TOUCH = 16'h014a;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 3'd4;

  localparam logic [RAW_W-1:0] X_MAX_RST = 16'd1919;
  localparam logic [RAW_W-1:0] Y_MAX_RST = 16'd479;

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  localparam logic KIND_DOT  = 1'b0;
  localparam logic KIND_LINE = 1'b1;

endpackage

// ===== hdl/touch_event_stroke_decoder_top.sv =====
// ----------------------------------------------------------------------------
// touch_event_stroke_decoder_top
// Decodes touch input events into dots and line segments in logical space.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one event transaction: ev_type,
// ev_code, ev_value. Output channel (out_valid/out_ready) carries one stroke
// transaction: stroke_kind, start_x/y, end_x/y. Configuration registers are
// written through cfg_wr_en/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Events that only update state (axis, tracking id, button release, sync
// without contact) leave the block idle. Events that need the logical point
// pass through the scale multiply, the two bit-serial restoring dividers (X
// and Y run side by side, one quotient bit per cycle) and a final step that
// rotates, saturates, compares and loads the output register. The output
// register lets the next event be taken while a stroke waits; any finished
// computation holds in its final step until the output register is free, so
// a stalled receiver stalls the input only once a second computation ends.
// Reset (rst, synchronous) restores the configuration defaults, clears the
// contact and touching flags, the raw and last logical points, and drops
// any pending stroke.
// ----------------------------------------------------------------------------
module touch_event_stroke_decoder_top #(
  parameter int LOGICAL_WIDTH  = 1920,
  parameter int LOGICAL_HEIGHT = 480
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [15:0]                         ev_type,
  input  logic [15:0]                         ev_code,
  input  logic signed [tsd_pkg::VAL_W-1:0]    ev_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                stroke_kind,
  output logic signed [tsd_pkg::POS_W-1:0]    start_x,
  output logic signed [tsd_pkg::POS_W-1:0]    start_y,
  output logic signed [tsd_pkg::POS_W-1:0]    end_x,
  output logic signed [tsd_pkg::POS_W-1:0]    end_y,
  input  logic                                cfg_wr_en,
  input  logic [tsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int RW     = tsd_pkg::RAW_W;
  localparam int PW     = tsd_pkg::POS_W;
  localparam int DIM_MX = (LOGICAL_WIDTH > LOGICAL_HEIGHT) ? LOGICAL_WIDTH : LOGICAL_HEIGHT;
  localparam int DIM_W  = $clog2(DIM_MX + 1);
  localparam int NUM_W  = RW + DIM_W;
  localparam int LW     = NUM_W + 2;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int DEN_W  = RW + 1;

  localparam logic [DIM_W-1:0]        DIM_X  = DIM_W'(LOGICAL_WIDTH);
  localparam logic [DIM_W-1:0]        DIM_Y  = DIM_W'(LOGICAL_HEIGHT);
  localparam logic signed [LW-1:0]    W_M1   = LW'(LOGICAL_WIDTH - 1);
  localparam logic signed [LW-1:0]    H_M1   = LW'(LOGICAL_HEIGHT - 1);
  localparam logic signed [LW-1:0]    SAT_HI = LW'((1 << (PW - 1)) - 1);
  localparam logic signed [LW-1:0]    SAT_LO = -LW'(1 << (PW - 1));
  localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(NUM_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state;

  logic [RW-1:0]           x_min, x_max, y_min, y_max;
  logic [tsd_pkg::ROT_W-1:0] rotation;
  logic [RW-1:0]           raw_x, raw_y;
  logic                    contact, touching;
  logic signed [PW-1:0]    prev_x, prev_y;
  logic                    is_dot;
  logic [CNT_W-1:0]        cnt;

  logic [RW-1:0]           mag [2];
  logic                    neg [2];
  logic                    ok  [2];
  logic [DEN_W-1:0]        den [2];
  logic [DEN_W-1:0]        rem [2];
  logic [NUM_W-1:0]        num [2];

  logic [RW-1:0]           lane_raw [2];
  logic [RW-1:0]           lane_min [2];
  logic [RW-1:0]           lane_max [2];
  logic [RW-1:0]           mag_in   [2];
  logic                    neg_in   [2];
  logic                    ok_in    [2];
  logic [DEN_W-1:0]        den_in   [2];
  logic [DEN_W:0]          rem_sh   [2];
  logic                    qbit     [2];
  logic [DEN_W-1:0]        rem_next [2];
  logic signed [LW-1:0]    nval     [2];
  logic signed [LW-1:0]    rot_x, rot_y;
  logic signed [PW-1:0]    lx, ly;

  logic                    accept;
  logic                    val_one, val_zero;
  logic [RW-1:0]           clamped;
  logic                    out_free;
  logic                    moved;
  logic                    emit;

  function automatic logic signed [PW-1:0] sat13(input logic signed [LW-1:0] v);
    if (v < SAT_LO) return SAT_LO[PW-1:0];
    if (v > SAT_HI) return SAT_HI[PW-1:0];
    return v[PW-1:0];
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign val_one  = (ev_value == 32'sd1);
  assign val_zero = (ev_value == 32'sd0);
  assign clamped  = ev_value[31] ? '0 : ((ev_value[30:16] != '0) ? '1 : ev_value[15:0]);
  assign moved    = (lx != prev_x) || (ly != prev_y);
  assign emit     = (state == ST_FIN) && out_free && (is_dot || moved);

  always_comb begin
    lane_raw[0] = raw_x;
    lane_raw[1] = raw_y;
    lane_min[0] = x_min;
    lane_min[1] = y_min;
    lane_max[0] = x_max;
    lane_max[1] = y_max;
    for (int i = 0; i < 2; i++) begin
      neg_in[i]   = lane_raw[i] < lane_min[i];
      mag_in[i]   = neg_in[i] ? (lane_min[i] - lane_raw[i]) : (lane_raw[i] - lane_min[i]);
      ok_in[i]    = lane_max[i] >= lane_min[i];
      den_in[i]   = DEN_W'(lane_max[i]) - DEN_W'(lane_min[i]) + DEN_W'(1);
      rem_sh[i]   = {rem[i], num[i][NUM_W-1]};
      qbit[i]     = rem_sh[i] >= {1'b0, den[i]};
      rem_next[i] = qbit[i] ? DEN_W'(rem_sh[i] - {1'b0, den[i]}) : rem_sh[i][DEN_W-1:0];
      if (!ok[i]) begin
        nval[i] = LW'(lane_raw[i]);
      end else if (neg[i]) begin
        nval[i] = -LW'(num[i]);
      end else begin
        nval[i] = LW'(num[i]);
      end
    end
    case (rotation)
      tsd_pkg::ROT_90: begin
        rot_x = H_M1 - nval[1];
        rot_y = nval[0];
      end
      tsd_pkg::ROT_180: begin
        rot_x = W_M1 - nval[0];
        rot_y = H_M1 - nval[1];
      end
      tsd_pkg::ROT_270: begin
        rot_x = nval[1];
        rot_y = W_M1 - nval[0];
      end
      default: begin
        rot_x = nval[0];
        rot_y = nval[1];
      end
    endcase
    lx = sat13(rot_x);
    ly = sat13(rot_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      x_min     <= '0;
      x_max     <= tsd_pkg::X_MAX_RST;
      y_min     <= '0;
      y_max     <= tsd_pkg::Y_MAX_RST;
      rotation  <= tsd_pkg::ROT_0;
      raw_x     <= '0;
      raw_y     <= '0;
      contact   <= 1'b0;
      touching  <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      is_dot    <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          tsd_pkg::REG_X_MIN:    x_min    <= cfg_data;
          tsd_pkg::REG_X_MAX:    x_max    <= cfg_data;
          tsd_pkg::REG_Y_MIN:    y_min    <= cfg_data;
          tsd_pkg::REG_Y_MAX:    y_max    <= cfg_data;
          tsd_pkg::REG_ROTATION: rotation <= cfg_data[tsd_pkg::ROT_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            for (int i = 0; i < 2; i++) begin
              mag[i] <= mag_in[i];
              neg[i] <= neg_in[i];
              ok[i]  <= ok_in[i];
              den[i] <= den_in[i];
            end
            if (ev_type == tsd_pkg::EVT_ABS) begin
              if (ev_code == tsd_pkg::CODE_MT_X || ev_code == tsd_pkg::CODE_X) begin
                raw_x <= clamped;
              end else if (ev_code == tsd_pkg::CODE_MT_Y || ev_code == tsd_pkg::CODE_Y) begin
                raw_y <= clamped;
              end else if (ev_code == tsd_pkg::CODE_TRACK) begin
                contact <= !ev_value[31];
              end
            end else if (ev_type == tsd_pkg::EVT_KEY && ev_code == tsd_pkg::CODE_BTN_TOUCH) begin
              if (val_one && !touching) begin
                touching <= 1'b1;
                is_dot   <= 1'b1;
                state    <= ST_MUL;
              end else if (val_zero) begin
                touching <= 1'b0;
              end
            end else if (ev_type == tsd_pkg::EVT_SYN) begin
              if (contact && !touching) begin
                touching <= 1'b1;
                is_dot   <= 1'b1;
                state    <= ST_MUL;
              end else if (!contact) begin
                touching <= 1'b0;
              end else begin
                is_dot <= 1'b0;
                state  <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          num[0] <= NUM_W'(mag[0]) * NUM_W'(DIM_X);
          num[1] <= NUM_W'(mag[1]) * NUM_W'(DIM_Y);
          rem[0] <= '0;
          rem[1] <= '0;
          cnt    <= '0;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          for (int i = 0; i < 2; i++) begin
            rem[i] <= rem_next[i];
            num[i] <= {num[i][NUM_W-2:0], qbit[i]};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (is_dot) begin
              stroke_kind <= tsd_pkg::KIND_DOT;
              start_x     <= lx;
              start_y     <= ly;
              end_x       <= lx;
              end_y       <= ly;
              prev_x      <= lx;
              prev_y      <= ly;
            end else if (moved) begin
              stroke_kind <= tsd_pkg::KIND_LINE;
              start_x     <= prev_x;
              start_y     <= prev_y;
              end_x       <= lx;
              end_y       <= ly;
              prev_x      <= lx;
              prev_y      <= ly;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb_touch_event_stroke_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_touch_event_stroke_decoder_top
// Self-checking bench for the touch event stroke decoder. A directed table
// covers reset state, clamping, saturation, the button and sync corner cases
// and ignored events; random touch gestures (multi-touch, legacy button,
// broken sequences and noise) then run under several panel ranges and all
// four rotations. Every stroke transaction is checked against the expected
// stroke in the directed table or from an in-bench stroke predictor, with
// random gaps on the event side and stalls on the stroke side.
// ----------------------------------------------------------------------------
module tb_touch_event_stroke_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsd_pkg::*;

  localparam int LOG_W         = 1920;
  localparam int LOG_H         = 480;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_EVENTS  = 170;
  localparam int NUM_PHASES    = 7;

  localparam logic [15:0] EVT_UNKNOWN      = 16'h0002;
  localparam logic [15:0] CODE_UNKNOWN_ABS = 16'h0030;
  localparam logic [15:0] CODE_UNKNOWN_KEY = 16'h014b;
  localparam logic [15:0] ALL_ONES16       = 16'hffff;
  localparam logic [15:0] ABS_CODES [5]    =
    '{CODE_X, CODE_Y, CODE_MT_X, CODE_MT_Y, CODE_TRACK};

  typedef struct packed {
    logic                    kind;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [POS_W-1:0] ex;
    logic signed [POS_W-1:0] ey;
  } stroke_t;

  typedef struct {
    logic [15:0]        t;
    logic [15:0]        c;
    logic signed [31:0] v;
    bit                 typed;
    bit                 has;
    stroke_t            res;
  } event_row_t;

  localparam stroke_t NO_STROKE = '0;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [15:0]             ev_type = '0;
  logic [15:0]             ev_code = '0;
  logic signed [VAL_W-1:0] ev_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    stroke_kind;
  logic signed [POS_W-1:0] start_x, start_y, end_x, end_y;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // predictor copy of configuration and state
  logic [15:0]             cfg_x_min = 16'd0;
  logic [15:0]             cfg_x_max = X_MAX_RST;
  logic [15:0]             cfg_y_min = 16'd0;
  logic [15:0]             cfg_y_max = Y_MAX_RST;
  logic [ROT_W-1:0]        cfg_rot = ROT_0;
  logic [15:0]             track_raw_x = '0;
  logic [15:0]             track_raw_y = '0;
  bit                      track_contact = 1'b0;
  bit                      track_touching = 1'b0;
  logic signed [POS_W-1:0] track_last_x = '0;
  logic signed [POS_W-1:0] track_last_y = '0;

  stroke_t expected_strokes [$];
  stroke_t seen_stroke, want_stroke;
  int      fail_count = 0;
  int      events_sent = 0;
  int      cycle_count = 0;
  int      hold_cnt = 0;
  bit      src_gaps = 1'b0;
  bit      sink_stalls = 1'b0;
  bit      quiet = 1'b0;

  event_row_t dir_table [27] = '{
    '{EVT_SYN, CODE_X, 32'sd0, 1'b1, 1'b0, NO_STROKE},
    '{EVT_ABS, CODE_X, 32'sd100, 1'b0, 1'b0, NO_STROKE},
    '{EVT_ABS, CODE_Y, 32'sd50, 1'b0, 1'b0, NO_STROKE},
    '{EVT_KEY, CODE_BTN_TOUCH, 32'sd1, 1'b1, 1'b1,
      '{KIND_DOT, 13'sd100, 13'sd50, 13'sd100, 13'sd50}},
    '{EVT_ABS, CODE_MT_X, 32'sd1919, 1'b0, 1'b0, NO_STROKE},
    '{EVT_ABS, CODE_MT_Y, 32'sd479, 1'b0, 1'b0, NO_STROKE},
    // legacy quirk: sync without contact drops touch
    '{EVT_SYN, CODE_X, 32'sd0, 1'b1, 1'b0, NO_STROKE},
    '{EVT_ABS, CODE_TRACK, 32'sd5, 1'b0, 1'b0, NO_STROKE},
    '{EVT_SYN, CODE_X, 32'sd0, 1'b1, 1'b1,
      '{KIND_DOT, 13'sd1919, 13'sd479, 13'sd1919, 13'sd479}},
    '{EVT_SYN, CODE_X, 32'sd0, 1'b1, 1'b0, NO_STROKE},
    '{EVT_ABS, CODE_X, -32'sd5, 1'b0, 1'b0, NO_STROKE},
    '{EVT_ABS, CODE_Y, 32'sh7fffffff, 1'b0, 1'b0, NO_STROKE},
    '{EVT_SYN, CODE_X, 32'sd0, 1'b1, 1'b1,
      '{KIND_LINE, 13'sd1919, 13'sd479, 13'sd0, 13'sd4095}},
    '{EVT_KEY, CODE_BTN_TOUCH, 32'sd1, 1'b1, 1'b0, NO_STROKE},
    '{EVT_KEY, CODE_BTN_TOUCH, 32'sd2, 1'b1, 1'b0, NO_STROKE},
    '{EVT_KEY, CODE_BTN_TOUCH, 32'sd0, 1'b0, 1'b0, NO_STROKE},
    '{EVT_KEY, CODE_BTN_TOUCH, -32'sd1, 1'b0, 1'b0, NO_STROKE},
    '{EVT_ABS, CODE_MT_X, 32'sh80000000, 1'b0, 1'b0, NO_STROKE},
    '{EVT_SYN, CODE_X, 32'sd0, 1'b1, 1'b1,
      '{KIND_DOT, 13'sd0, 13'sd4095, 13'sd0, 13'sd4095}},
    '{EVT_UNKNOWN, CODE_X, 32'sd0, 1'b0, 1'b0, NO_STROKE},
    '{ALL_ONES16, ALL_ONES16, -32'sd1, 1'b0, 1'b0, NO_STROKE},
    '{EVT_ABS, CODE_UNKNOWN_ABS, 32'sd123, 1'b0, 1'b0, NO_STROKE},
    '{EVT_KEY, CODE_UNKNOWN_KEY, 32'sd1, 1'b0, 1'b0, NO_STROKE},
    '{EVT_SYN, ALL_ONES16, -32'sd1, 1'b1, 1'b0, NO_STROKE},
    '{EVT_ABS, CODE_TRACK, -32'sd1, 1'b0, 1'b0, NO_STROKE},
    '{EVT_SYN, CODE_X, 32'sd0, 1'b1, 1'b0, NO_STROKE},
    '{EVT_KEY, CODE_BTN_TOUCH, 32'sd1, 1'b1, 1'b1,
      '{KIND_DOT, 13'sd0, 13'sd4095, 13'sd0, 13'sd4095}}
  };

  touch_event_stroke_decoder_top #(
    .LOGICAL_WIDTH (LOG_W),
    .LOGICAL_HEIGHT(LOG_H)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ev_type    (ev_type),
    .ev_code    (ev_code),
    .ev_value   (ev_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stroke_kind(stroke_kind),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint map_axis(longint raw, longint lo, longint hi, longint size);
    longint span;
    span = hi - lo + 1;
    if (span > 0) return (raw - lo) * size / span;
    return raw;
  endfunction

  function automatic logic signed [POS_W-1:0] clip13(longint v);
    if (v < -4096) return -13'sd4096;
    if (v > 4095) return 13'sd4095;
    return v[POS_W-1:0];
  endfunction

  function automatic void locate(output logic signed [POS_W-1:0] lx,
                                 output logic signed [POS_W-1:0] ly);
    longint nx, ny, x, y;
    nx = map_axis(track_raw_x, cfg_x_min, cfg_x_max, LOG_W);
    ny = map_axis(track_raw_y, cfg_y_min, cfg_y_max, LOG_H);
    case (cfg_rot)
      ROT_90:  begin x = LOG_H - 1 - ny; y = nx; end
      ROT_180: begin x = LOG_W - 1 - nx; y = LOG_H - 1 - ny; end
      ROT_270: begin x = ny; y = LOG_W - 1 - nx; end
      default: begin x = nx; y = ny; end
    endcase
    lx = clip13(x);
    ly = clip13(y);
  endfunction

  function automatic bit place_dot(output stroke_t s);
    logic signed [POS_W-1:0] lx, ly;
    track_touching = 1'b1;
    locate(lx, ly);
    track_last_x = lx;
    track_last_y = ly;
    s = '{KIND_DOT, lx, ly, lx, ly};
    return 1'b1;
  endfunction

  function automatic bit decode_event(logic [15:0] t, logic [15:0] c,
                                      logic signed [31:0] v, output stroke_t s);
    logic signed [POS_W-1:0] lx, ly;
    longint val;
    logic [15:0] clamped;
    val = v;
    s = NO_STROKE;
    if (t == EVT_ABS) begin
      clamped = (val < 0) ? 16'd0 : (val > 65535) ? 16'hffff : val[15:0];
      if (c == CODE_MT_X || c == CODE_X) track_raw_x = clamped;
      else if (c == CODE_MT_Y || c == CODE_Y) track_raw_y = clamped;
      else if (c == CODE_TRACK) track_contact = (val >= 0);
      return 1'b0;
    end
    if (t == EVT_KEY && c == CODE_BTN_TOUCH) begin
      if (val == 1 && !track_touching) return place_dot(s);
      if (val == 0) track_touching = 1'b0;
      return 1'b0;
    end
    if (t == EVT_SYN) begin
      if (track_contact && !track_touching) return place_dot(s);
      if (!track_contact) begin
        track_touching = 1'b0;
        return 1'b0;
      end
      locate(lx, ly);
      if (lx != track_last_x || ly != track_last_y) begin
        s = '{KIND_LINE, track_last_x, track_last_y, lx, ly};
        track_last_x = lx;
        track_last_y = ly;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- stroke checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_stroke = '{stroke_kind, start_x, start_y, end_x, end_y};
        if (expected_strokes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected stroke kind=%0d start=(%0d,%0d) end=(%0d,%0d)",
                     seen_stroke.kind, seen_stroke.sx, seen_stroke.sy,
                     seen_stroke.ex, seen_stroke.ey);
        end else begin
          want_stroke = expected_strokes.pop_front();
          if (seen_stroke.kind !== want_stroke.kind || seen_stroke.sx !== want_stroke.sx ||
              seen_stroke.sy !== want_stroke.sy || seen_stroke.ex !== want_stroke.ex ||
              seen_stroke.ey !== want_stroke.ey) begin
            fail_count++;
            if (fail_count <= 10)
              $display("stroke mismatch: exp kind=%0d (%0d,%0d)->(%0d,%0d) got kind=%0d (%0d,%0d)->(%0d,%0d)",
                       want_stroke.kind, want_stroke.sx, want_stroke.sy,
                       want_stroke.ex, want_stroke.ey, seen_stroke.kind,
                       seen_stroke.sx, seen_stroke.sy, seen_stroke.ex, seen_stroke.ey);
          end
        end
      end
      if (hold_cnt != 0) begin
        out_ready <= 1'b0;
        hold_cnt  <= hold_cnt - 1;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        hold_cnt  <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- event driver
  task automatic send_event(input logic [15:0] t, input logic [15:0] c,
                            input logic signed [31:0] v, input bit counted,
                            input bit typed, input bit has, input stroke_t want);
    stroke_t s;
    bit      got;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ev_type  <= t;
    ev_code  <= c;
    ev_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = decode_event(t, c, v, s);
    if (typed) begin
      got = has;
      s   = want;
    end
    if (got) expected_strokes.push_back(s);
    if (counted) events_sent++;
  endtask

  task automatic post_event(input logic [15:0] t, input logic [15:0] c,
                            input logic signed [31:0] v);
    send_event(t, c, v, 1'b1, 1'b0, 1'b0, NO_STROKE);
  endtask

  // drop valid, wait out every stroke and the tail of a silent computation
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_strokes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_X_MIN:    cfg_x_min = data;
      REG_X_MAX:    cfg_x_max = data;
      REG_Y_MIN:    cfg_y_min = data;
      REG_Y_MAX:    cfg_y_max = data;
      REG_ROTATION: cfg_rot = data[ROT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] x_lo, input logic [15:0] x_hi,
                               input logic [15:0] y_lo, input logic [15:0] y_hi,
                               input logic [ROT_W-1:0] rot);
    settle();
    write_reg(REG_X_MIN, x_lo);
    write_reg(REG_X_MAX, x_hi);
    write_reg(REG_Y_MIN, y_lo);
    write_reg(REG_Y_MAX, y_hi);
    write_reg(REG_ROTATION, {{(16 - ROT_W){1'b0}}, rot});
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_coord(logic [15:0] lo, logic [15:0] hi);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 65535);
      2: return $urandom_range(0, 1) ? lo : hi;
      3: return -$urandom_range(1, 1000);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic run_gesture();
    logic [15:0] xc, yc;
    xc = $urandom_range(0, 1) ? CODE_MT_X : CODE_X;
    yc = $urandom_range(0, 1) ? CODE_MT_Y : CODE_Y;
    src_gaps    = !quiet && $urandom_range(0, 2) != 0;
    sink_stalls = !quiet && $urandom_range(0, 2) != 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        // multi-touch contact: down, moves, lift
        post_event(EVT_ABS, CODE_TRACK, {1'b0, 31'($urandom)});
        post_event(EVT_ABS, xc, pick_coord(cfg_x_min, cfg_x_max));
        post_event(EVT_ABS, yc, pick_coord(cfg_y_min, cfg_y_max));
        post_event(EVT_SYN, CODE_X, 32'sd0);
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 3) != 0) post_event(EVT_ABS, xc, pick_coord(cfg_x_min, cfg_x_max));
          if ($urandom_range(0, 3) != 0) post_event(EVT_ABS, yc, pick_coord(cfg_y_min, cfg_y_max));
          post_event(EVT_SYN, CODE_X, 32'sd0);
        end
        post_event(EVT_ABS, CODE_TRACK, -32'sd1);
        post_event(EVT_SYN, CODE_X, 32'sd0);
      end
      6, 7: begin
        // legacy single-touch with button
        post_event(EVT_ABS, xc, pick_coord(cfg_x_min, cfg_x_max));
        post_event(EVT_ABS, yc, pick_coord(cfg_y_min, cfg_y_max));
        post_event(EVT_KEY, CODE_BTN_TOUCH, 32'sd1);
        post_event(EVT_SYN, CODE_X, 32'sd0);
        post_event(EVT_ABS, xc, pick_coord(cfg_x_min, cfg_x_max));
        post_event(EVT_KEY, CODE_BTN_TOUCH, 32'sd1);
        post_event(EVT_SYN, CODE_X, 32'sd0);
        post_event(EVT_KEY, CODE_BTN_TOUCH, 32'sd0);
        post_event(EVT_SYN, CODE_X, 32'sd0);
      end
      8: begin
        repeat ($urandom_range(3, 10)) begin
          case ($urandom_range(0, 4))
            0: post_event(EVT_ABS, ABS_CODES[$urandom_range(0, 4)], $urandom);
            1: case ($urandom_range(0, 4))
                 0: post_event(EVT_KEY, CODE_BTN_TOUCH, 32'sd0);
                 1: post_event(EVT_KEY, CODE_BTN_TOUCH, 32'sd1);
                 2: post_event(EVT_KEY, CODE_BTN_TOUCH, 32'sd2);
                 3: post_event(EVT_KEY, CODE_BTN_TOUCH, -32'sd1);
                 default: post_event(EVT_KEY, CODE_BTN_TOUCH, $urandom);
               endcase
            2: post_event(EVT_SYN, 16'($urandom), $urandom);
            3: post_event(EVT_ABS, xc, pick_coord(cfg_x_min, cfg_x_max));
            default: post_event(EVT_ABS, CODE_TRACK, $urandom_range(0, 1) ? -32'sd1 : 32'sd7);
          endcase
        end
      end
      default: begin
        repeat ($urandom_range(1, 3))
          send_event(16'($urandom), 16'($urandom), $urandom, 1'b0, 1'b0, 1'b0, NO_STROKE);
      end
    endcase
  endtask

  initial begin
    logic [15:0] xa, ya;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(dir_table); i++)
      send_event(dir_table[i].t, dir_table[i].c, dir_table[i].v, 1'b1,
                 dir_table[i].typed, dir_table[i].has, dir_table[i].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      xa = $urandom_range(0, 2000);
      ya = $urandom_range(0, 2000);
      case (p)
        0: apply_setting(16'd0, 16'hffff, 16'd0, 16'hffff, ROT_90);
        1: apply_setting(xa, xa + 16'($urandom_range(0, 4000)), ya,
                         ya + 16'($urandom_range(0, 1000)), ROT_180);
        2: apply_setting(16'hffff, 16'd0, 16'd1000, 16'd999, ROT_90);
        3: apply_setting(16'd500, 16'd500, 16'd0, 16'd0, ROT_270);
        4: apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         ROT_W'($urandom));
        5: apply_setting(16'd0, X_MAX_RST, 16'd0, Y_MAX_RST, ROT_0);
        default: apply_setting(xa, xa + 16'($urandom_range(0, 3000)), ya,
                               ya + 16'($urandom_range(0, 800)), ROT_W'($urandom));
      endcase
      quiet = (p == NUM_PHASES - 1);
      while (events_sent < (p + 1) * PHASE_EVENTS) run_gesture();
    end

    settle();
    if (fail_count == 0 && expected_strokes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tsd_pkg.sv
hdl/touch_event_stroke_decoder_top.sv
bench/tb_touch_event_stroke_decoder_top.sv
